/* rtl/tspcm_pkg.sv */
// ----------------------------------------------------------------------------
// tspcm_pkg: shared types and constants of the TS PID continuity monitor
// Field widths, per-PID table entry layout, result layout and status group.
// ----------------------------------------------------------------------------
package tspcm_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int OUT_W       = 32;
  localparam int PID_W       = 13;
  localparam int PID_DEPTH   = 1 << PID_W;
  localparam int CC_W        = 4;
  localparam int AFC_W       = 2;
  localparam int SYNC_W      = 8;

  localparam logic [SYNC_W-1:0] SYNC_VALUE = 8'h47;
  localparam logic [PID_W-1:0]  NULL_PID   = 13'h1FFF;

  localparam logic [AFC_W-1:0] AFC_RESERVED = 2'b00;
  localparam logic [AFC_W-1:0] AFC_PAYLOAD  = 2'b01;
  localparam logic [AFC_W-1:0] AFC_ADAPT    = 2'b10;
  localparam logic [AFC_W-1:0] AFC_BOTH     = 2'b11;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic [SYNC_W-1:0] sync_byte;
    logic [PID_W-1:0]  packet_pid;
    logic [AFC_W-1:0]  adapt_ctrl;
    logic [CC_W-1:0]   cont_count;
    logic              discont_flag;
  } hdr_t;

  typedef struct packed {
    logic            seen;
    logic [CC_W-1:0] last_cc;
    count_t          packets;
    count_t          errors;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             ignored;
    logic             cc_error;
    logic [OUT_W-1:0] pid_packets;
    logic [OUT_W-1:0] pid_errors;
    logic [OUT_W-1:0] afc00_disc_total;
    logic [OUT_W-1:0] afc00_plain_total;
  } result_t;

  typedef struct packed {
    logic clearing;
    logic s1_valid;
  } core_status_t;

endpackage

/* rtl/tspcm_if.sv */
// ----------------------------------------------------------------------------
// tspcm_if: header and result channels of the TS PID continuity monitor
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tspcm_hdr_if;
  logic                              valid;
  logic                              ready;
  logic [tspcm_pkg::SYNC_W-1:0]      sync_byte;
  logic [tspcm_pkg::PID_W-1:0]       packet_pid;
  logic [tspcm_pkg::AFC_W-1:0]       adapt_ctrl;
  logic [tspcm_pkg::CC_W-1:0]        cont_count;
  logic                              discont_flag;

  modport source (output valid, sync_byte, packet_pid, adapt_ctrl, cont_count, discont_flag,
                  input ready);
  modport sink (input valid, sync_byte, packet_pid, adapt_ctrl, cont_count, discont_flag,
                output ready);
endinterface

interface tspcm_res_if;
  logic                         valid;
  logic                         ready;
  logic                         ignored;
  logic                         cc_error;
  logic [tspcm_pkg::OUT_W-1:0]  pid_packets;
  logic [tspcm_pkg::OUT_W-1:0]  pid_errors;
  logic [tspcm_pkg::OUT_W-1:0]  afc00_disc_total;
  logic [tspcm_pkg::OUT_W-1:0]  afc00_plain_total;

  modport source (output valid, ignored, cc_error, pid_packets, pid_errors,
                  afc00_disc_total, afc00_plain_total, input ready);
  modport sink (input valid, ignored, cc_error, pid_packets, pid_errors,
                afc00_disc_total, afc00_plain_total, output ready);
endinterface

/* rtl/ts_pid_continuity_monitor_top.sv */
// ----------------------------------------------------------------------------
// ts_pid_continuity_monitor_top: MPEG-TS per-PID continuity counter monitor
// Checks continuity counters per PID and reports per-PID and global counts.
//
//   Port   Direction  Content
//   hdr    sink       one packet header item (sync, PID, AFC, CC, discontinuity)
//   res    source     one result item per header item
//
// One item per cycle sustained while the result sink is ready; a result is
// registered in the result buffer. After reset all 8192 PID table entries
// are cleared, one entry per cycle, and no header is taken until the sweep ends.
// A stalled result sink is absorbed by a two-entry buffer; a header is taken
// while the update stage and that buffer hold at most one item between them,
// or two when a result leaves in the same cycle.
// ----------------------------------------------------------------------------
module ts_pid_continuity_monitor_top (
  input logic         clk,
  input logic         rst,
  tspcm_hdr_if.sink   hdr,
  tspcm_res_if.source res
);

  tspcm_pkg::hdr_t         hdr_data;
  tspcm_pkg::core_status_t status;
  tspcm_pkg::result_t      core_res;
  tspcm_pkg::result_t      head;
  logic                    core_push;
  logic                    head_valid;
  logic                    pop;
  logic [1:0]              fifo_cnt;
  logic [2:0]              occupancy;
  logic                    hdr_accept;

  assign hdr_data.sync_byte    = hdr.sync_byte;
  assign hdr_data.packet_pid   = hdr.packet_pid;
  assign hdr_data.adapt_ctrl   = hdr.adapt_ctrl;
  assign hdr_data.cont_count   = hdr.cont_count;
  assign hdr_data.discont_flag = hdr.discont_flag;

  assign pop        = head_valid && res.ready;
  assign occupancy  = 3'(status.s1_valid) + 3'(fifo_cnt);
  assign hdr.ready  = !status.clearing && (occupancy <= 3'd1 + 3'(pop));
  assign hdr_accept = hdr.valid && hdr.ready;

  tspcm_core u_core (
    .clk        (clk),
    .rst        (rst),
    .hdr_accept (hdr_accept),
    .hdr        (hdr_data),
    .status     (status),
    .res_push   (core_push),
    .res        (core_res)
  );

  tspcm_out_fifo u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (core_push),
    .push_data  (core_res),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head),
    .cnt        (fifo_cnt)
  );

  assign res.valid             = head_valid;
  assign res.ignored           = head.ignored;
  assign res.cc_error          = head.cc_error;
  assign res.pid_packets       = head.pid_packets;
  assign res.pid_errors        = head.pid_errors;
  assign res.afc00_disc_total  = head.afc00_disc_total;
  assign res.afc00_plain_total = head.afc00_plain_total;

endmodule

/* rtl/tspcm_ram.sv */
// ----------------------------------------------------------------------------
// tspcm_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module tspcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tspcm_out_fifo.sv */
// ----------------------------------------------------------------------------
// tspcm_out_fifo: two-entry result buffer
// Decouples the read-modify-write stage from a stalled result sink.
// ----------------------------------------------------------------------------
module tspcm_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tspcm_pkg::result_t push_data,
  input  logic               pop,
  output logic               head_valid,
  output tspcm_pkg::result_t head_data,
  output logic [1:0]         cnt
);

  tspcm_pkg::result_t slots [2];
  logic wr_ptr;
  logic rd_ptr;

  assign head_valid = (cnt != 2'd0);
  assign head_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (cnt != 2'd2) || pop)
    else $error("result buffer overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> cnt != 2'd0)
    else $error("result buffer underflow");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("result buffer count out of range");

endmodule

/* rtl/tspcm_core.sv */
// ----------------------------------------------------------------------------
// tspcm_core: per-PID read-modify-write engine
// Reads the PID entry at accept, checks and updates it in the next cycle with
// forwarding from the previous write, and clears the table after reset.
// ----------------------------------------------------------------------------
module tspcm_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        hdr_accept,
  input  tspcm_pkg::hdr_t             hdr,
  output tspcm_pkg::core_status_t     status,
  output logic                        res_push,
  output tspcm_pkg::result_t          res
);

  logic                              clearing;
  logic [tspcm_pkg::PID_W-1:0]       clr_addr;
  logic                              s1_valid;
  logic                              s1_ignored;
  tspcm_pkg::hdr_t                   s1_hdr;
  logic                              fwd_valid;
  logic [tspcm_pkg::PID_W-1:0]       fwd_pid;
  tspcm_pkg::entry_t                 fwd_entry;
  tspcm_pkg::count_t                 disc_total;
  tspcm_pkg::count_t                 plain_total;
  tspcm_pkg::count_t                 disc_total_next;
  tspcm_pkg::count_t                 plain_total_next;

  logic [tspcm_pkg::ENTRY_W-1:0]     ram_rdata;
  logic [tspcm_pkg::ENTRY_W-1:0]     ram_wdata;
  logic [tspcm_pkg::PID_W-1:0]       ram_waddr;
  logic                              ram_we;
  tspcm_pkg::entry_t                 cur;
  tspcm_pkg::entry_t                 upd;
  logic                              checked;
  logic                              err;
  logic [tspcm_pkg::CC_W-1:0]        cc_inc;
  logic                              s1_write;

  tspcm_ram #(
    .WIDTH (tspcm_pkg::ENTRY_W),
    .DEPTH (tspcm_pkg::PID_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (hdr.packet_pid),
    .rdata (ram_rdata)
  );

  always_comb begin
    cur = tspcm_pkg::entry_t'(ram_rdata);
    if (fwd_valid && (fwd_pid == s1_hdr.packet_pid)) begin
      cur = fwd_entry;
    end
    cc_inc           = cur.last_cc + 1'b1;
    checked          = !s1_ignored && cur.seen && (s1_hdr.packet_pid != tspcm_pkg::NULL_PID);
    err              = 1'b0;
    disc_total_next  = disc_total;
    plain_total_next = plain_total;
    case (s1_hdr.adapt_ctrl)
      tspcm_pkg::AFC_PAYLOAD: err = checked && (cc_inc != s1_hdr.cont_count);
      tspcm_pkg::AFC_BOTH: err = checked && !s1_hdr.discont_flag
                                 && (cc_inc != s1_hdr.cont_count);
      tspcm_pkg::AFC_ADAPT: err = checked && (cur.last_cc != s1_hdr.cont_count);
      tspcm_pkg::AFC_RESERVED: begin
        if (checked && s1_hdr.discont_flag) begin
          disc_total_next = disc_total + 1'b1;
        end
        if (checked && !s1_hdr.discont_flag) begin
          plain_total_next = plain_total + 1'b1;
        end
      end
      default: err = 1'b0;
    endcase
    upd = cur;
    if (!s1_ignored) begin
      upd.seen    = 1'b1;
      upd.last_cc = s1_hdr.cont_count;
      upd.packets = cur.packets + 1'b1;
      upd.errors  = err ? cur.errors + 1'b1 : cur.errors;
    end
  end

  assign s1_write  = s1_valid && !s1_ignored;
  assign ram_we    = clearing || s1_write;
  assign ram_waddr = clearing ? clr_addr : s1_hdr.packet_pid;
  assign ram_wdata = clearing ? '0 : tspcm_pkg::ENTRY_W'(upd);

  assign res_push              = s1_valid;
  assign res.ignored           = s1_ignored;
  assign res.cc_error          = err;
  assign res.pid_packets       = tspcm_pkg::OUT_W'(upd.packets);
  assign res.pid_errors        = tspcm_pkg::OUT_W'(upd.errors);
  assign res.afc00_disc_total  = tspcm_pkg::OUT_W'(disc_total_next);
  assign res.afc00_plain_total = tspcm_pkg::OUT_W'(plain_total_next);

  assign status.clearing = clearing;
  assign status.s1_valid = s1_valid;

  always_ff @(posedge clk) begin
    if (hdr_accept) begin
      s1_hdr     <= hdr;
      s1_ignored <= (hdr.sync_byte != tspcm_pkg::SYNC_VALUE);
    end
    if (s1_write) begin
      fwd_pid   <= s1_hdr.packet_pid;
      fwd_entry <= upd;
    end
    if (rst) begin
      clearing    <= 1'b1;
      clr_addr    <= '0;
      s1_valid    <= 1'b0;
      fwd_valid   <= 1'b0;
      disc_total  <= '0;
      plain_total <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == tspcm_pkg::PID_W'(tspcm_pkg::PID_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      s1_valid <= hdr_accept;
      if (s1_write) begin
        fwd_valid <= 1'b1;
      end
      if (s1_valid) begin
        disc_total  <= disc_total_next;
        plain_total <= plain_total_next;
      end
    end
  end

  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !hdr_accept && !s1_valid)
    else $error("item taken during table clear");

  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    clearing |=> !clearing || (clr_addr == $past(clr_addr) + 1'b1))
    else $error("clear sweep skipped an entry");

  a_ignored_quiet: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_ignored |-> !err && (disc_total_next == disc_total)
                              && (plain_total_next == plain_total))
    else $error("ignored item changed state");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: regression bench for the TS PID continuity monitor
// Feeds packet header items through the header channel and checks every
// result item against a predictor that keeps its own per-PID counter table,
// per-PID packet and error counts, and the two global AFC 00 totals. Both
// channels idle at random, with calm stretches, and the sender drains the
// block completely at least once.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 700;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    tspcm_pkg::hdr_t h;
    bit              drain;
  } header_item_t;

  logic clk;
  logic rst;

  tspcm_hdr_if hdr_ch ();
  tspcm_res_if res_ch ();

  ts_pid_continuity_monitor_top dut (
    .clk (clk),
    .rst (rst),
    .hdr (hdr_ch),
    .res (res_ch)
  );

  header_item_t       header_backlog[$];
  tspcm_pkg::result_t expected_reports[$];

  logic [tspcm_pkg::CC_W:0] cc_table [tspcm_pkg::PID_DEPTH];
  tspcm_pkg::count_t        pkt_tbl  [tspcm_pkg::PID_DEPTH];
  tspcm_pkg::count_t        err_tbl  [tspcm_pkg::PID_DEPTH];
  tspcm_pkg::count_t        afc00_disc;
  tspcm_pkg::count_t        afc00_plain;

  logic [tspcm_pkg::CC_W-1:0] gen_cc [tspcm_pkg::PID_DEPTH];

  int fail_count;
  int mismatch_count;
  int cycle_count;
  int drv_gap;
  int drv_calm;
  int mon_stall;
  int mon_calm;

  always #1 clk = ~clk;

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic tspcm_pkg::result_t track_continuity(tspcm_pkg::hdr_t h);
    tspcm_pkg::result_t         r;
    logic [tspcm_pkg::CC_W:0]   entry;
    logic [tspcm_pkg::CC_W-1:0] next_cc;
    logic                       err;
    err = 1'b0;
    r.ignored = (h.sync_byte != tspcm_pkg::SYNC_VALUE);
    if (!r.ignored) begin
      entry = cc_table[h.packet_pid];
      next_cc = entry[tspcm_pkg::CC_W-1:0] + 4'd1;
      pkt_tbl[h.packet_pid] = pkt_tbl[h.packet_pid] + 1'b1;
      if (h.packet_pid != tspcm_pkg::NULL_PID && entry[tspcm_pkg::CC_W]) begin
        case (h.adapt_ctrl)
          tspcm_pkg::AFC_PAYLOAD: err = (next_cc != h.cont_count);
          tspcm_pkg::AFC_BOTH: begin
            if (!h.discont_flag) err = (next_cc != h.cont_count);
          end
          tspcm_pkg::AFC_ADAPT: err = (entry[tspcm_pkg::CC_W-1:0] != h.cont_count);
          default: begin
            if (h.discont_flag) afc00_disc = afc00_disc + 1'b1;
            else afc00_plain = afc00_plain + 1'b1;
          end
        endcase
        if (err) err_tbl[h.packet_pid] = err_tbl[h.packet_pid] + 1'b1;
      end
      cc_table[h.packet_pid] = {1'b1, h.cont_count};
    end
    r.cc_error          = err;
    r.pid_packets       = pkt_tbl[h.packet_pid][tspcm_pkg::OUT_W-1:0];
    r.pid_errors        = err_tbl[h.packet_pid][tspcm_pkg::OUT_W-1:0];
    r.afc00_disc_total  = afc00_disc[tspcm_pkg::OUT_W-1:0];
    r.afc00_plain_total = afc00_plain[tspcm_pkg::OUT_W-1:0];
    return r;
  endfunction

  task automatic add_header(input logic [tspcm_pkg::SYNC_W-1:0] sync,
                            input logic [tspcm_pkg::PID_W-1:0] pid,
                            input logic [tspcm_pkg::AFC_W-1:0] afc,
                            input logic [tspcm_pkg::CC_W-1:0] cc,
                            input logic disc, input bit drain);
    header_item_t it;
    it.h.sync_byte    = sync;
    it.h.packet_pid   = pid;
    it.h.adapt_ctrl   = afc;
    it.h.cont_count   = cc;
    it.h.discont_flag = disc;
    it.drain          = drain;
    header_backlog.insert(header_backlog.size(), it);
  endtask

  task automatic compare_field(input string name, input logic [tspcm_pkg::OUT_W-1:0] want,
                               input logic [tspcm_pkg::OUT_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : drive_headers
    if (rst) begin
      hdr_ch.valid <= 1'b0;
      drv_gap = 0;
    end else begin
      if (hdr_ch.valid && hdr_ch.ready) begin
        expected_reports.insert(expected_reports.size(),
                                track_continuity(header_backlog[0].h));
        void'(header_backlog.pop_front());
        if (drv_calm > 0) drv_calm--;
        else if ($urandom_range(0, 63) == 0) drv_calm = $urandom_range(20, 120);
        drv_gap = (drv_calm > 0) ? 0 : pick_idle();
      end
      if (!hdr_ch.valid || hdr_ch.ready) begin
        if (drv_gap > 0) begin
          drv_gap--;
          hdr_ch.valid <= 1'b0;
        end else if (header_backlog.size() != 0 &&
                     (!header_backlog[0].drain || expected_reports.size() == 0)) begin
          hdr_ch.valid        <= 1'b1;
          hdr_ch.sync_byte    <= header_backlog[0].h.sync_byte;
          hdr_ch.packet_pid   <= header_backlog[0].h.packet_pid;
          hdr_ch.adapt_ctrl   <= header_backlog[0].h.adapt_ctrl;
          hdr_ch.cont_count   <= header_backlog[0].h.cont_count;
          hdr_ch.discont_flag <= header_backlog[0].h.discont_flag;
        end else begin
          hdr_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_results
    tspcm_pkg::result_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
      mon_stall = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_reports.size() == 0) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10) $display("result item arrived with none expected");
        end else begin
          want = expected_reports.pop_front();
          compare_field("ignored", tspcm_pkg::OUT_W'(want.ignored),
                        tspcm_pkg::OUT_W'(res_ch.ignored));
          compare_field("cc_error", tspcm_pkg::OUT_W'(want.cc_error),
                        tspcm_pkg::OUT_W'(res_ch.cc_error));
          compare_field("pid_packets", want.pid_packets, res_ch.pid_packets);
          compare_field("pid_errors", want.pid_errors, res_ch.pid_errors);
          compare_field("afc00_disc_total", want.afc00_disc_total, res_ch.afc00_disc_total);
          compare_field("afc00_plain_total", want.afc00_plain_total,
                        res_ch.afc00_plain_total);
        end
      end
      if (mon_stall > 0) begin
        mon_stall--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if (mon_calm > 0) mon_calm--;
        else if ($urandom_range(0, 127) == 0) mon_calm = $urandom_range(30, 150);
        mon_stall = (mon_calm > 0) ? 0 : pick_idle();
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ts_pid_continuity_monitor_top regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [tspcm_pkg::PID_W-1:0]  pid_pool [6];
    logic [tspcm_pkg::SYNC_W-1:0] sync;
    logic [tspcm_pkg::PID_W-1:0]  pid;
    logic [tspcm_pkg::AFC_W-1:0]  afc;
    logic [tspcm_pkg::CC_W-1:0]   cc;
    logic                         disc;
    int                           r;

    clk = 1'b0;
    rst = 1'b1;
    hdr_ch.valid        = 1'b0;
    hdr_ch.sync_byte    = '0;
    hdr_ch.packet_pid   = '0;
    hdr_ch.adapt_ctrl   = '0;
    hdr_ch.cont_count   = '0;
    hdr_ch.discont_flag = 1'b0;
    res_ch.ready        = 1'b0;
    fail_count     = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    drv_calm       = 0;
    mon_calm       = 0;
    afc00_disc     = '0;
    afc00_plain    = '0;
    for (int i = 0; i < tspcm_pkg::PID_DEPTH; i++) begin
      cc_table[i] = '0;
      pkt_tbl[i]  = '0;
      err_tbl[i]  = '0;
      gen_cc[i]   = '0;
    end

    add_header(8'h00, 13'd100, tspcm_pkg::AFC_PAYLOAD, 4'd3, 1'b0, 1'b0);
    add_header(tspcm_pkg::SYNC_VALUE, 13'd100, tspcm_pkg::AFC_PAYLOAD, 4'd15, 1'b0, 1'b0);
    add_header(tspcm_pkg::SYNC_VALUE, 13'd100, tspcm_pkg::AFC_PAYLOAD, 4'd0, 1'b0, 1'b0);
    add_header(tspcm_pkg::SYNC_VALUE, 13'd100, tspcm_pkg::AFC_PAYLOAD, 4'd5, 1'b0, 1'b0);
    add_header(tspcm_pkg::SYNC_VALUE, 13'd100, tspcm_pkg::AFC_ADAPT, 4'd5, 1'b0, 1'b0);
    add_header(tspcm_pkg::SYNC_VALUE, 13'd100, tspcm_pkg::AFC_ADAPT, 4'd6, 1'b1, 1'b0);
    add_header(tspcm_pkg::SYNC_VALUE, 13'd100, tspcm_pkg::AFC_BOTH, 4'd7, 1'b0, 1'b0);
    add_header(tspcm_pkg::SYNC_VALUE, 13'd100, tspcm_pkg::AFC_BOTH, 4'd3, 1'b0, 1'b0);
    add_header(tspcm_pkg::SYNC_VALUE, 13'd100, tspcm_pkg::AFC_BOTH, 4'd9, 1'b1, 1'b0);
    add_header(tspcm_pkg::SYNC_VALUE, 13'd100, tspcm_pkg::AFC_RESERVED, 4'd2, 1'b1, 1'b0);
    add_header(tspcm_pkg::SYNC_VALUE, 13'd100, tspcm_pkg::AFC_RESERVED, 4'd11, 1'b0, 1'b0);
    add_header(8'h46, 13'd100, tspcm_pkg::AFC_PAYLOAD, 4'd12, 1'b0, 1'b0);
    add_header(8'h48, 13'd100, tspcm_pkg::AFC_ADAPT, 4'd0, 1'b1, 1'b0);
    add_header(tspcm_pkg::SYNC_VALUE, tspcm_pkg::NULL_PID, tspcm_pkg::AFC_PAYLOAD, 4'd0,
               1'b0, 1'b0);
    add_header(tspcm_pkg::SYNC_VALUE, tspcm_pkg::NULL_PID, tspcm_pkg::AFC_PAYLOAD, 4'd9,
               1'b0, 1'b0);
    add_header(tspcm_pkg::SYNC_VALUE, tspcm_pkg::NULL_PID, tspcm_pkg::AFC_ADAPT, 4'd3,
               1'b0, 1'b0);
    add_header(tspcm_pkg::SYNC_VALUE, tspcm_pkg::NULL_PID, tspcm_pkg::AFC_RESERVED, 4'd4,
               1'b1, 1'b0);
    add_header(tspcm_pkg::SYNC_VALUE, 13'd0, tspcm_pkg::AFC_RESERVED, 4'd0, 1'b0, 1'b0);
    add_header(tspcm_pkg::SYNC_VALUE, 13'd0, tspcm_pkg::AFC_RESERVED, 4'd15, 1'b0, 1'b0);
    add_header(tspcm_pkg::SYNC_VALUE, 13'd0, tspcm_pkg::AFC_PAYLOAD, 4'd0, 1'b0, 1'b0);
    add_header(8'hFF, tspcm_pkg::NULL_PID, tspcm_pkg::AFC_BOTH, 4'd15, 1'b1, 1'b0);
    add_header(tspcm_pkg::SYNC_VALUE, 13'd4096, tspcm_pkg::AFC_ADAPT, 4'd8, 1'b0, 1'b0);
    add_header(tspcm_pkg::SYNC_VALUE, 13'd4096, tspcm_pkg::AFC_ADAPT, 4'd9, 1'b0, 1'b0);
    add_header(tspcm_pkg::SYNC_VALUE, 13'd100, tspcm_pkg::AFC_PAYLOAD, 4'd12, 1'b0, 1'b0);

    for (int i = 0; i < 6; i++)
      pid_pool[i] = tspcm_pkg::PID_W'($urandom_range(0, tspcm_pkg::PID_DEPTH - 2));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 75) pid = pid_pool[$urandom_range(0, 5)];
      else if (r < 80) pid = tspcm_pkg::NULL_PID;
      else pid = tspcm_pkg::PID_W'($urandom_range(0, tspcm_pkg::PID_DEPTH - 1));
      sync = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                         : tspcm_pkg::SYNC_VALUE;
      afc  = tspcm_pkg::AFC_W'($urandom_range(0, 3));
      disc = ($urandom_range(0, 3) == 0);
      cc   = tspcm_pkg::CC_W'($urandom_range(0, 15));
      if ($urandom_range(0, 99) < 85) begin
        if (afc == tspcm_pkg::AFC_PAYLOAD || (afc == tspcm_pkg::AFC_BOTH && !disc))
          cc = gen_cc[pid] + 4'd1;
        else if (afc == tspcm_pkg::AFC_ADAPT) cc = gen_cc[pid];
      end
      if (sync == tspcm_pkg::SYNC_VALUE) gen_cc[pid] = cc;
      add_header(sync, pid, afc, cc, disc, (i == 0) || (i == RANDOM_ITEMS / 2));
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (header_backlog.size() != 0) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_reports.size() == 0)
      $display("ts_pid_continuity_monitor_top regression: pass");
    else
      $display("ts_pid_continuity_monitor_top regression: fail");
    $finish;
  end
endmodule
